### rtl/dca_pkg.sv
// shared constants and codes for the dma channel allocator
package dca_pkg;

  localparam int unsigned NumChannelsDefault = 12;
  localparam int unsigned MaxChannels = 16;

  localparam int unsigned IdWidth = 5;
  localparam int unsigned GrantWidth = 4;
  localparam int unsigned PrioWidth = 2;
  localparam int unsigned StatusWidth = 2;

  typedef logic [StatusWidth-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_FREE   = 2'd1;
  localparam status_t ST_BAD_ID    = 2'd2;
  localparam status_t ST_NOT_ALLOC = 2'd3;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

endpackage

### rtl/dma_channel_allocator_top.sv
// dma channel allocator: per-core ownership bitmaps with named or first-free grant
//
//   channel   valid     ready      payload
//   ------    --------  ---------  -------------------------------------------------
//   request   in_valid  in_ready   func, channel_id, core, irq_priority
//   result    out_valid out_ready  status, granted_channel, vector_enable,
//                                  vector_disable, vector_priority,
//                                  engine_unreset, engine_reset
//
// one transaction per cycle sustained while the result is not stalled; a
// request passes the request register, then the result register
// the ownership masks update at the same edge that loads the result
// register, so the next request in the request register sees them at once
// rst (synchronous, active high) clears both masks and both valid flags
// a stalled result holds the result register; the request register still
// drains into it when it empties, and in_ready drops only when both are full
module dma_channel_allocator_top #(
  parameter int unsigned NUM_CHANNELS = dca_pkg::NumChannelsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [dca_pkg::IdWidth-1:0]       channel_id,
  input  logic                              core,
  input  logic [dca_pkg::PrioWidth-1:0]     irq_priority,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dca_pkg::StatusWidth-1:0]   status,
  output logic [dca_pkg::GrantWidth-1:0]    granted_channel,
  output logic                              vector_enable,
  output logic                              vector_disable,
  output logic [dca_pkg::PrioWidth-1:0]     vector_priority,
  output logic                              engine_unreset,
  output logic                              engine_reset
);

  // ownership state, one bit per channel and core
  logic [NUM_CHANNELS-1:0] core0_owned;
  logic [NUM_CHANNELS-1:0] core1_owned;
  logic [NUM_CHANNELS-1:0] core0_owned_next;
  logic [NUM_CHANNELS-1:0] core1_owned_next;

  // request register
  logic                          req_valid;
  logic                          req_func;
  logic [dca_pkg::IdWidth-1:0]   req_id;
  logic                          req_core;
  logic [dca_pkg::PrioWidth-1:0] req_prio;

  // handshake
  logic advance;
  logic in_fire;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_fire) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func <= func;
      req_id   <= channel_id;
      req_core <= core;
      req_prio <= irq_priority;
    end
  end

  // decode of the requested channel
  logic [NUM_CHANNELS-1:0] id_onehot;
  logic                    id_named;
  logic                    id_any;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      id_onehot[i] = (req_id == dca_pkg::IdWidth'(i));
    end
  end

  assign id_named = (req_id < dca_pkg::IdWidth'(NUM_CHANNELS));
  assign id_any   = (req_id == dca_pkg::IdWidth'(NUM_CHANNELS));

  // masks seen by this request
  logic [NUM_CHANNELS-1:0] both;
  logic [NUM_CHANNELS-1:0] own;
  logic [NUM_CHANNELS-1:0] other;
  logic [NUM_CHANNELS-1:0] free_mask;

  assign both      = core0_owned | core1_owned;
  assign own       = req_core ? core1_owned : core0_owned;
  assign other     = req_core ? core0_owned : core1_owned;
  assign free_mask = ~both;

  // lowest free channel, priority encoded
  logic [NUM_CHANNELS-1:0]          first_free_onehot;
  logic [dca_pkg::GrantWidth-1:0]   first_free_idx;

  assign first_free_onehot = free_mask & (~free_mask + NUM_CHANNELS'(1));

  always_comb begin
    first_free_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        first_free_idx = dca_pkg::GrantWidth'(i);
      end
    end
  end

  // result of this request
  logic [NUM_CHANNELS-1:0]        own_new;
  logic [NUM_CHANNELS-1:0]        grant_onehot;
  logic [dca_pkg::GrantWidth-1:0] grant_idx;
  logic                           found;
  dca_pkg::status_t               res_status;
  logic [dca_pkg::GrantWidth-1:0] res_grant;
  logic                           res_ven;
  logic                           res_vdis;
  logic [dca_pkg::PrioWidth-1:0]  res_vpri;
  logic                           res_unrst;
  logic                           res_rst;

  always_comb begin
    grant_onehot = id_named ? id_onehot : first_free_onehot;
    grant_idx    = id_named ? req_id[dca_pkg::GrantWidth-1:0] : first_free_idx;
    found        = 1'b0;
    own_new      = own;
    res_status   = dca_pkg::ST_OK;
    res_grant    = '0;
    res_ven      = 1'b0;
    res_vdis     = 1'b0;
    res_vpri     = '0;
    res_unrst    = 1'b0;
    res_rst      = 1'b0;

    if (dca_pkg::func_t'(req_func) == dca_pkg::FUNC_ALLOC) begin
      if (id_named) begin
        found = ((both & id_onehot) == '0);
      end else if (id_any) begin
        found = (free_mask != '0);
      end
      if (!id_named && !id_any) begin
        res_status = dca_pkg::ST_BAD_ID;
      end else if (!found) begin
        res_status = dca_pkg::ST_NO_FREE;
      end else begin
        own_new   = own | grant_onehot;
        res_grant = grant_idx;
        res_ven   = (own == '0);
        res_vpri  = (own == '0) ? req_prio : '0;
        res_unrst = (both == '0);
      end
    end else begin
      if (!id_named) begin
        res_status = dca_pkg::ST_BAD_ID;
      end else if ((both & id_onehot) == '0) begin
        res_status = dca_pkg::ST_NOT_ALLOC;
      end else begin
        // owned only by the other core leaves the mask as it was
        own_new  = own & ~id_onehot;
        res_vdis = (own_new == '0);
        res_rst  = ((own_new | other) == '0);
      end
    end
  end

  assign core0_owned_next = req_core ? core0_owned : own_new;
  assign core1_owned_next = req_core ? own_new : core1_owned;

  always_ff @(posedge clk) begin
    if (rst) begin
      core0_owned <= '0;
      core1_owned <= '0;
    end else if (advance) begin
      core0_owned <= core0_owned_next;
      core1_owned <= core1_owned_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status          <= res_status;
      granted_channel <= res_grant;
      vector_enable   <= res_ven;
      vector_disable  <= res_vdis;
      vector_priority <= res_vpri;
      engine_unreset  <= res_unrst;
      engine_reset    <= res_rst;
    end
  end

endmodule
